// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/hls_pkg.sv =====
package hls_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_t;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 9;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    op_t   operation;
    word_t value;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    word_t                popped_value;
    logic [COUNT_W-1:0]   entry_count;
    word_t                content_hash;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_top;
    logic walk;
    logic finish;
  } hls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic walk_done;
    logic out_free;
  } hls_sts_t;

  // h*33 + d, mod 2^64
  function automatic word_t hash_step(input word_t h, input word_t d);
    hash_step = (h << 5) + h + d;
  endfunction

endpackage

// ===== hw/rtl/hls_ctrl.sv =====
module hls_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  hls_pkg::op_t     op,
  input  hls_pkg::hls_sts_t sts,
  output logic             in_ready,
  output hls_pkg::hls_cmd_t cmd
);
  import hls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TOP  = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_POP:   state_nxt = sts.empty ? S_IDLE : S_TOP;
            OP_CHECK: state_nxt = S_WALK;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_TOP:  state_nxt = S_WALK;
      S_WALK: if (sts.walk_done) state_nxt = S_FIN;
      S_FIN:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.accept   = accept;
    cmd.load_top = (state_r == S_TOP);
    cmd.walk     = (state_r == S_WALK);
    cmd.finish   = (state_r == S_FIN) && sts.out_free;
  end

endmodule

// ===== hw/rtl/hls_dpath.sv =====
module hls_dpath #(
  parameter int unsigned DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hls_pkg::in_item_t  in_data,
  input  hls_pkg::hls_cmd_t  cmd,
  output hls_pkg::hls_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output hls_pkg::out_item_t out_data
);
  import hls_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  word_t mem [DEPTH];
  word_t rdata_r;

  logic [CW-1:0] count_r, count_nxt;
  word_t         hash_r, hash_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;

  logic [CW-1:0] walk_len_r;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic          pend_r, pend_nxt;
  word_t         acc_r, acc_nxt;
  word_t         popped_r;
  op_t           op_r;

  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] raddr;
  logic          full, empty, issue_more, quick, load;
  out_item_t     res;

  assign cnt_dec    = count_r - CW'(1);
  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);
  assign issue_more = (issue_idx_r != walk_len_r);
  assign quick      = cmd.accept && ((in_data.operation == OP_PUSH) ||
                      (in_data.operation == OP_CLEAR) ||
                      ((in_data.operation == OP_POP) && empty));
  assign load       = quick || cmd.finish;

  assign raddr = cmd.accept ? cnt_dec[AW-1:0] : issue_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.operation == OP_PUSH) && !full) begin
      mem[count_r[AW-1:0]] <= in_data.value;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    count_nxt = count_r;
    hash_nxt  = hash_r;
    if (cmd.accept) begin
      case (in_data.operation)
        OP_PUSH: begin
          if (!full) begin
            count_nxt = count_r + CW'(1);
            hash_nxt  = hash_step(hash_r, in_data.value);
          end
        end
        OP_POP:   if (!empty) count_nxt = cnt_dec;
        OP_CLEAR: begin
          count_nxt = '0;
          hash_nxt  = '0;
        end
        default: ;
      endcase
    end else if (cmd.finish && (op_r == OP_POP)) begin
      hash_nxt = acc_r;
    end
  end

  always_comb begin
    res.popped_value = '0;
    res.entry_count  = COUNT_W'(count_nxt);
    res.content_hash = hash_nxt;
    res.status       = ST_OK;
    if (quick) begin
      if ((in_data.operation == OP_PUSH) && full) res.status = ST_OVERFLOW;
      if ((in_data.operation == OP_POP) && empty) res.status = ST_UNDERFLOW;
    end else if (op_r == OP_POP) begin
      res.popped_value = popped_r;
    end else if (acc_r != hash_r) begin
      res.status = ST_MISMATCH;
    end
  end

  // hash walk over entries 0 .. walk_len-1, one read per cycle
  always_comb begin
    issue_idx_nxt = issue_idx_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    if (cmd.accept) begin
      issue_idx_nxt = '0;
      pend_nxt      = 1'b0;
      acc_nxt       = '0;
    end else if (cmd.walk) begin
      pend_nxt = issue_more;
      if (issue_more) issue_idx_nxt = issue_idx_r + CW'(1);
      if (pend_r) acc_nxt = hash_step(acc_r, rdata_r);
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx_r <= issue_idx_nxt;
    acc_r       <= acc_nxt;
    if (cmd.accept) begin
      op_r       <= in_data.operation;
      walk_len_r <= (in_data.operation == OP_POP) ? cnt_dec : count_r;
    end
    if (cmd.load_top) popped_r <= rdata_r;
    if (load) out_data_r <= res;
  end

  always_comb begin
    sts.empty     = empty;
    sts.walk_done = !issue_more && !pend_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/hashed_lifo_stack_top.sv =====
// LIFO stack of 64-bit words with a running content hash h = h*33 + word,
// bottom to top, mod 2^64. Push, clear, push on a full stack and pop on an
// empty one need no walk: the result is registered at the accepting
// edge and the next beat can be taken in the following cycle if that result
// is not stalled on the output. A successful pop reads the top word and then
// rehashes the remaining entries through the single read port of the stack
// memory before its result is registered. A check walks all held entries
// the same way. Both also wait while the previous result is still stalled on
// the output. One operation is in flight at a time. entry_count carries the
// low 9 bits of the count.
`include "assert_macros.svh"

module hashed_lifo_stack_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hls_pkg::out_item_t out_data
);
  import hls_pkg::*;

  hls_cmd_t cmd;
  hls_sts_t sts;

  hls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .op       (in_data.operation),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  hls_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_NEVER(a_ready_out_blocked, in_ready && out_valid && !out_ready, "ready while result stalled")
  `ASSERT_CLK(a_check_busy, in_valid && in_ready && (in_data.operation == OP_CHECK) |=> !in_ready, "check did not go busy")
  `ASSERT_CLK(a_underflow_empty, out_valid && (out_data.status == ST_UNDERFLOW) |-> (out_data.entry_count == '0) && (out_data.popped_value == '0), "underflow on nonempty stack")

endmodule
